// ===== rtl/fir31_pkg.sv =====
// Shared constants, coefficient table and register map of the 31-tap FIR.
`default_nettype none

package fir31_pkg;

  localparam int TAP_COUNT = 31;
  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 16;
  localparam int MAX_TAPS  = 33;

  localparam int PROD_W = SAMPLE_W + COEF_W;
  localparam int ACC_W  = PROD_W + $clog2(TAP_COUNT);

  localparam logic signed [ACC_W-1:0] RND_CONST = ACC_W'(64'sd1 <<< (COEF_W - 2));

  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'((64'sd1 <<< (SAMPLE_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - ACC_W'(1);

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic REG_FILTER_ENABLE = 1'b0;

  localparam logic signed [15:0] COEF_Q15 [MAX_TAPS] = '{
    16'sd0,     -16'sd218,  -16'sd373,  -16'sd317,  16'sd0,     16'sd448,   16'sd751,
    16'sd630,   16'sd0,     -16'sd902,  -16'sd1552, -16'sd1364, 16'sd0,     16'sd2391,
    16'sd5151,  16'sd7353,  16'sd8192,  16'sd7353,  16'sd5151,  16'sd2391,  16'sd0,
    -16'sd1364, -16'sd1552, -16'sd902,  16'sd0,     16'sd630,   16'sd751,   16'sd448,
    16'sd0,     -16'sd317,  -16'sd373,  -16'sd218,  16'sd0
  };

  function automatic logic signed [COEF_W-1:0] coef_at(int k);
    int c;
    c = int'(COEF_Q15[k]);
    if (COEF_W >= 16) begin
      return COEF_W'(c <<< (COEF_W - 16));
    end else begin
      return COEF_W'((c + (1 <<< (15 - COEF_W))) >>> (16 - COEF_W));
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/fir31_cell.sv =====
// One transposed-form tap: multiply the broadcast sample and add the neighbor's partial sum.
`default_nettype none

module fir31_cell
  import fir31_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     advance_i,
  input  wire logic signed [SAMPLE_W-1:0] sample_i,
  input  wire logic signed [COEF_W-1:0]   coef_i,
  input  wire logic signed [ACC_W-1:0]    sum_i,
  output logic signed [ACC_W-1:0]         sum_o
);

  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  sum_d, sum_q;

  assign prod  = coef_i * sample_i;
  assign sum_d = ACC_W'(prod) + sum_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= RND_CONST;
    end else if (advance_i) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

`default_nettype wire

// ===== rtl/fir31_out.sv =====
// Head tap, rounding, saturation, bypass select and output register with handshake.
`default_nettype none

module fir31_out
  import fir31_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic signed [SAMPLE_W-1:0] sample_i,
  input  wire logic signed [COEF_W-1:0]   coef_i,
  input  wire logic signed [ACC_W-1:0]    head_sum_i,
  input  wire logic                       enable_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0]      sample_o
);

  logic                       in_fire;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    scaled;
  logic signed [SAMPLE_W-1:0] filt;
  logic signed [SAMPLE_W-1:0] data_d, data_q;
  logic                       valid_d, valid_q;

  assign in_ready_o = !valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign prod   = coef_i * sample_i;
  assign acc    = ACC_W'(prod) + head_sum_i;
  assign scaled = acc >>> (COEF_W - 1);

  always_comb begin
    priority if (scaled > SAT_MAX) begin
      filt = SAT_MAX[SAMPLE_W-1:0];
    end else if (scaled < SAT_MIN) begin
      filt = SAT_MIN[SAMPLE_W-1:0];
    end else begin
      filt = scaled[SAMPLE_W-1:0];
    end
  end

  assign data_d  = enable_i ? filt : sample_i;
  assign valid_d = in_fire || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign sample_o    = data_q;

  a_fire_gives_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> valid_q)
    else $error("accepted beat did not produce a result");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_fire && (!valid_q || out_ready_i)) |=> !valid_q)
    else $error("result appeared without an input beat");

  a_bypass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !enable_i) |=> (data_q == $past(sample_i)))
    else $error("bypass result differs from input");

  a_sat_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && enable_i && (scaled > SAT_MAX)) |=> (data_q == SAT_MAX[SAMPLE_W-1:0]))
    else $error("positive overflow not clamped");

  a_sat_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && enable_i && (scaled < SAT_MIN)) |=> (data_q == SAT_MIN[SAMPLE_W-1:0]))
    else $error("negative overflow not clamped");

endmodule

`default_nettype wire

// ===== rtl/fir_lowpass_filter_31_tap.sv =====
// Top level of the 31-tap low-pass FIR: tap chain, output stage and APB register.
// Latency: a result is valid in the cycle after its input beat is accepted.
// Throughput: one beat per clock while the output side takes results; the tap chain advances on every accepted beat.
// The output register decouples the sides; input is stalled only while it holds an untaken beat.
// Reset loads the rounding constant into all partial sums (zero history) and clears enable.
`default_nettype none

module fir_lowpass_filter_31_tap
  import fir31_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // slave stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [SAMPLE_W-1:0]   s_axis_tdata,   // [15:0] sample_in
  // master stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [SAMPLE_W-1:0]        m_axis_tdata,   // [15:0] sample_out
  // configuration
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0]      prdata,
  output logic                       pready
);

  logic                       advance;
  logic                       enable_d, enable_q;
  logic                       reg_wr;
  logic signed [SAMPLE_W-1:0] sample;
  logic signed [SAMPLE_W-1:0] result;
  logic signed [ACC_W-1:0]    part_sum [1:TAP_COUNT];

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_FILTER_ENABLE);

  assign enable_d = reg_wr ? pwdata[0] : enable_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
    end else begin
      enable_q <= enable_d;
    end
  end

  assign prdata = (paddr[2] == REG_FILTER_ENABLE) ? {{(APB_DATA_W-1){1'b0}}, enable_q}
                                                  : '0;

  assign sample  = $signed(s_axis_tdata);
  assign advance = s_axis_tvalid && s_axis_tready;

  assign part_sum[TAP_COUNT] = RND_CONST;

  for (genvar k = 1; k < TAP_COUNT; k++) begin : g_tap
    fir31_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .advance_i (advance),
      .sample_i  (sample),
      .coef_i    (coef_at(k)),
      .sum_i     (part_sum[k+1]),
      .sum_o     (part_sum[k])
    );
  end

  fir31_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .sample_i    (sample),
    .coef_i      (coef_at(0)),
    .head_sum_i  (part_sum[1]),
    .enable_i    (enable_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sample_o    (result)
  );

  assign m_axis_tdata = result;

endmodule

`default_nettype wire
